[sv/ihrd_pkg.sv]
package ihrd_pkg;

  localparam int RouteEntriesDefault = 64;

  localparam logic [63:0] V4Map = 64'h0000_ffff_0000_0000;
  localparam logic [5:0]  V4Hdr = 6'd20;
  localparam logic [5:0]  V6Hdr = 6'd40;
  localparam logic [3:0]  VerFour = 4'd4;
  localparam logic [3:0]  VerSix  = 4'd6;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_REG   = 2'd1,
    OP_UNREG = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    VD_MALFORMED = 3'd0,
    VD_REJECTED  = 3'd1,
    VD_ENDPOINT  = 3'd2,
    VD_OUTSIDE   = 3'd3,
    VD_STORED    = 3'd4,
    VD_NOEFFECT  = 3'd5,
    VD_FULL      = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_DEL  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CFG_CHECK_EN = 3'd0,
    CFG_V4_VALID = 3'd1,
    CFG_V4_SRC   = 3'd2,
    CFG_V6_VALID = 3'd3,
    CFG_V6_HIGH  = 3'd4,
    CFG_V6_LOW   = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_OUTPUT
  } state_t;

  typedef enum logic [1:0] {
    JOB_PACKET,
    JOB_REG,
    JOB_UNREG
  } job_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [63:0] route_addr_high;
    logic [63:0] route_addr_low;
    logic [7:0]  endpoint_id;
    logic [63:0] owner_high;
    logic [63:0] owner_low;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  target_endpoint;
    logic        is_version_six;
    logic [5:0]  header_length;
    logic [15:0] payload_length;
    logic [1:0]  os_route_action;
  } out_word_t;

  typedef struct packed {
    logic take_byte;
    logic start;
    job_t job;
    logic scan_step;
    logic commit;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic scan_done;
    logic frame_end;
  } sts_t;

endpackage

[sv/ihrd_datapath.sv]
module ihrd_datapath #(
  parameter int ROUTE_ENTRIES = ihrd_pkg::RouteEntriesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  ihrd_pkg::in_word_t  in_word,
  input  ihrd_pkg::ctl_t      ctl,
  output ihrd_pkg::sts_t      sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output ihrd_pkg::out_word_t out_word
);
  import ihrd_pkg::*;

  localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CW = $clog2(ROUTE_ENTRIES + 1);

  logic        check_en, v4_valid, v6_valid;
  logic [31:0] v4_src;
  logic [63:0] v6_high, v6_low;

  logic [15:0]  byte_count;
  logic [3:0]   packet_version;
  logic [127:0] src, dst;

  logic [ROUTE_ENTRIES-1:0] entry_valid;
  logic [127:0] mem_addr  [ROUTE_ENTRIES];
  logic [7:0]   mem_ep    [ROUTE_ENTRIES];
  logic [127:0] mem_owner [ROUTE_ENTRIES];
  logic [127:0] rd_addr, rd_owner;
  logic [7:0]   rd_ep;

  job_t         job;
  logic [127:0] key, owner;
  logic [7:0]   ep_in;
  logic [15:0]  len;
  logic         six, bad_frame, src_bad;
  logic [CW-1:0] scan;
  logic [IW-1:0] rd_idx, hit_idx, free_idx;
  logic          rd_live, hit, has_free;
  logic [7:0]    out_ep;
  logic [127:0]  out_own;

  logic [IW-1:0] idx;
  logic [15:0]   pos;
  logic [127:0]  dst_v4;
  logic          hit_now;

  assign idx = scan[IW-1:0];
  assign pos = byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_en <= 1'b0;
      v4_valid <= 1'b0;
      v4_src   <= '0;
      v6_valid <= 1'b0;
      v6_high  <= '0;
      v6_low   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHECK_EN: check_en <= cfg_data[0];
        CFG_V4_VALID: v4_valid <= cfg_data[0];
        CFG_V4_SRC:   v4_src   <= cfg_data[31:0];
        CFG_V6_VALID: v6_valid <= cfg_data[0];
        CFG_V6_HIGH:  v6_high  <= cfg_data;
        CFG_V6_LOW:   v6_low   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      packet_version <= '0;
      src            <= '0;
      dst            <= '0;
    end else if (ctl.take_byte) begin
      logic [3:0] ver;
      ver = (pos == 16'd0) ? in_word.data_byte[7:4] : packet_version;
      if (pos == 16'd0) begin
        packet_version <= ver;
        src <= '0;
        dst <= '0;
      end
      if (ver == VerFour) begin
        if (pos >= 16'd12 && pos < 16'd16) src <= {src[119:0], in_word.data_byte};
        else if (pos >= 16'd16 && pos < 16'd20) dst <= {dst[119:0], in_word.data_byte};
      end else if (ver == VerSix) begin
        if (pos >= 16'd8 && pos < 16'd24) src <= {src[119:0], in_word.data_byte};
        else if (pos >= 16'd24 && pos < 16'd40) dst <= {dst[119:0], in_word.data_byte};
      end
      if (in_word.last_byte) begin
        byte_count <= '0;
      end else if (byte_count != 16'hffff) begin
        byte_count <= byte_count + 16'd1;
      end
    end
  end

  assign dst_v4 = {64'd0, V4Map | {32'd0, dst[31:0]}};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      logic [15:0] l;
      l = (byte_count != 16'hffff) ? byte_count + 16'd1 : byte_count;
      job   <= ctl.job;
      owner <= {in_word.owner_high, in_word.owner_low};
      ep_in <= in_word.endpoint_id;
      len   <= l;
      if (ctl.job == JOB_PACKET) begin
        logic [3:0] ver;
        ver = (byte_count == 16'd0) ? in_word.data_byte[7:4] : packet_version;
        six <= (ver == VerSix);
        bad_frame <= !(ver == VerFour || ver == VerSix) ||
                     l < ((ver == VerSix) ? {10'd0, V6Hdr} : {10'd0, V4Hdr});
      end else begin
        six <= 1'b0;
        bad_frame <= 1'b0;
        key <= {in_word.route_addr_high, in_word.route_addr_low};
      end
    end else if (ctl.scan_step && scan == '0 && job == JOB_PACKET) begin
      key <= six ? dst : dst_v4;
      src_bad <= six ? (!v6_valid || src != {v6_high, v6_low})
                     : (!v4_valid || src[31:0] != v4_src);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      scan     <= '0;
      rd_live  <= 1'b0;
      hit      <= 1'b0;
      has_free <= 1'b0;
    end else if (ctl.scan_step) begin
      if (scan < CW'(ROUTE_ENTRIES)) begin
        rd_addr  <= mem_addr[idx];
        rd_ep    <= mem_ep[idx];
        rd_owner <= mem_owner[idx];
        rd_idx   <= idx;
        rd_live  <= entry_valid[idx];
        scan     <= scan + CW'(1);
        if (!entry_valid[idx] && !has_free) begin
          has_free <= 1'b1;
          free_idx <= idx;
        end
      end else begin
        rd_live <= 1'b0;
      end
      if (hit_now && !hit) begin
        hit     <= 1'b1;
        hit_idx <= rd_idx;
        out_ep  <= rd_ep;
        out_own <= rd_owner;
      end
    end
  end

  assign hit_now = rd_live && rd_addr == key && scan != '0;
  assign sts = '{scan_done: (scan == CW'(ROUTE_ENTRIES)) && !rd_live,
                 frame_end: in_word.last_byte};

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (job == JOB_REG) begin
        if (hit) begin
          mem_ep[hit_idx]    <= ep_in;
          mem_owner[hit_idx] <= owner;
        end else if (has_free) begin
          mem_addr[free_idx]  <= key;
          mem_ep[free_idx]    <= ep_in;
          mem_owner[free_idx] <= owner;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ctl.commit) begin
      if (job == JOB_REG && !hit && has_free) entry_valid[free_idx] <= 1'b1;
      else if (job == JOB_UNREG && hit && out_own == owner) entry_valid[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_word_t res;
      res = '0;
      case (job)
        JOB_PACKET: begin
          if (bad_frame) begin
            res.verdict = VD_MALFORMED;
          end else begin
            res.is_version_six = six;
            res.header_length  = six ? V6Hdr : V4Hdr;
            res.payload_length = len - (six ? {10'd0, V6Hdr} : {10'd0, V4Hdr});
            if (check_en && src_bad) begin
              res.verdict = VD_REJECTED;
            end else if (hit) begin
              res.verdict = VD_ENDPOINT;
              res.target_endpoint = out_ep;
            end else begin
              res.verdict = VD_OUTSIDE;
            end
          end
        end
        JOB_REG: begin
          if (hit) begin
            res.verdict = VD_STORED;
          end else if (has_free) begin
            res.verdict = VD_STORED;
            res.os_route_action = ACT_ADD;
          end else begin
            res.verdict = VD_FULL;
          end
        end
        JOB_UNREG: begin
          if (hit && out_own == owner) begin
            res.verdict = VD_STORED;
            res.os_route_action = ACT_DEL;
          end else begin
            res.verdict = VD_NOEFFECT;
          end
        end
        default: res.verdict = VD_NOEFFECT;
      endcase
      out_word <= res;
    end
  end

endmodule

[sv/ihrd_control.sv]
module ihrd_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_opcode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ihrd_pkg::ctl_t ctl,
  input  ihrd_pkg::sts_t sts
);
  import ihrd_pkg::*;

  state_t state, state_next;
  logic   acc;

  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (in_opcode == OP_REG || in_opcode == OP_UNREG) state_next = ST_SEARCH;
          else if (in_opcode == OP_BYTE && sts.frame_end) state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: if (sts.scan_done) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUTPUT;
      ST_OUTPUT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.job = JOB_PACKET;
    case (state)
      ST_IDLE: begin
        ctl.take_byte = acc && in_opcode == OP_BYTE;
        ctl.start = acc && (in_opcode == OP_REG || in_opcode == OP_UNREG ||
                            (in_opcode == OP_BYTE && sts.frame_end));
        if (in_opcode == OP_REG) ctl.job = JOB_REG;
        else if (in_opcode == OP_UNREG) ctl.job = JOB_UNREG;
      end
      ST_SEARCH: ctl.scan_step = 1'b1;
      ST_DECIDE: ctl.commit = 1'b1;
      ST_OUTPUT: ctl.load_out = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUTPUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

[sv/ip_header_route_dispatch.sv]
// IP header classifier with an exact-match route table. Packet bytes are
// taken while idle; the last byte of a packet, and each register or unregister
// word, starts a scan of the route table that reads one entry per cycle. When
// the scan is done, any table update is committed and then the result is registered.
// The result is held until taken, and no new word is taken meanwhile; input
// is ready again the cycle after the result is taken.
// Configuration writes land immediately; the table is empty after reset.
module ip_header_route_dispatch #(
  parameter int ROUTE_ENTRIES = ihrd_pkg::RouteEntriesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ihrd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ihrd_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import ihrd_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ihrd_control u_ctrl (
    .clk, .rst, .in_valid, .in_opcode(in_data.opcode), .in_ready,
    .out_valid, .out_ready, .ctl, .sts
  );

  ihrd_datapath #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_dp (
    .clk, .rst, .in_word(in_data), .ctl, .sts,
    .cfg_we, .cfg_index, .cfg_data, .out_word(out_data)
  );

endmodule

[sv/ihrd_checker.sv]
module ihrd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ihrd_pkg::out_word_t out_data
);
  import ihrd_pkg::*;

  a_no_take_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.verdict != 3'd7) else $error("bad verdict");

  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.header_length == 6'd0 || out_data.header_length == V4Hdr ||
                   out_data.header_length == V6Hdr)) else $error("bad header length");

endmodule

bind ip_header_route_dispatch ihrd_checker u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .out_data
);
